// ----- src/pimr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pimr_pkg: shared types and constants of the point-in-mesh ray parity unit
// Widths of the exact integer ray/triangle test and the step table of the
// shared multiply-accumulate sequence.
// ----------------------------------------------------------------------------
package pimr_pkg;

    localparam int COORD_BITS = 24;
    localparam int COUNT_BITS = 16;

    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW + 1;
    localparam int LW  = DW + 1;
    localparam int HW  = PW - LW;
    localparam int MW  = DW + 2;
    localparam int PRW = 2 * MW;
    localparam int TW  = 3 * DW + 3;

    localparam int N_COORDS = 9;
    localparam int IN_W     = ((N_COORDS * CW + 7) / 8) * 8;
    localparam int OUT_W    = ((COUNT_BITS + 2 + 7) / 8) * 8;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Z = 2'd2;

    localparam int N_MAC     = 16;
    localparam int MAC_IDX_W = $clog2(N_MAC);
    localparam int STEP_W    = $clog2(N_MAC + 1);

    typedef enum logic [3:0] {
        SRC_E1X, SRC_E1Y, SRC_E1Z,
        SRC_E2X, SRC_E2Y, SRC_E2Z,
        SRC_SX,  SRC_SY,  SRC_SZ,
        SRC_QXL, SRC_QXH, SRC_QYL, SRC_QYH, SRC_QZL, SRC_QZH
    } t_src;

    typedef enum logic [1:0] {
        ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB
    } t_acc_op;

    typedef enum logic [2:0] {
        DST_NONE, DST_DET, DST_U, DST_QX, DST_QY, DST_QZ, DST_T
    } t_dst;

    typedef struct packed {
        logic    en;
        t_src    a_src;
        t_src    b_src;
        t_acc_op op;
        logic    hi;
        t_dst    dst;
    } t_mac_cmd;

    typedef struct packed {
        logic     capture;
        t_mac_cmd mac;
        logic     eval;
        logic     decide;
        logic     emit;
    } t_dp_cmd;

    function automatic t_mac_cmd mk(t_src a, t_src b, t_acc_op op, logic hi, t_dst dst);
        t_mac_cmd c;
        c.en    = 1'b1;
        c.a_src = a;
        c.b_src = b;
        c.op    = op;
        c.hi    = hi;
        c.dst   = dst;
        return c;
    endfunction

    // The determinant, u and the three components of s x e1 are two-product
    // cross terms; t is the dot product of e2 with s x e1, each component of
    // which is split into a low unsigned and a high signed chunk.
    function automatic t_mac_cmd step_cmd(logic [MAC_IDX_W-1:0] step);
        t_mac_cmd c;
        c = '0;
        case (step)
            4'd0:  c = mk(SRC_E1Z, SRC_E2Y, ACC_LOAD, 1'b0, DST_NONE);
            4'd1:  c = mk(SRC_E1Y, SRC_E2Z, ACC_SUB,  1'b0, DST_DET);
            4'd2:  c = mk(SRC_SZ,  SRC_E2Y, ACC_LOAD, 1'b0, DST_NONE);
            4'd3:  c = mk(SRC_SY,  SRC_E2Z, ACC_SUB,  1'b0, DST_U);
            4'd4:  c = mk(SRC_SY,  SRC_E1Z, ACC_LOAD, 1'b0, DST_NONE);
            4'd5:  c = mk(SRC_SZ,  SRC_E1Y, ACC_SUB,  1'b0, DST_QX);
            4'd6:  c = mk(SRC_SZ,  SRC_E1X, ACC_LOAD, 1'b0, DST_NONE);
            4'd7:  c = mk(SRC_SX,  SRC_E1Z, ACC_SUB,  1'b0, DST_QY);
            4'd8:  c = mk(SRC_SX,  SRC_E1Y, ACC_LOAD, 1'b0, DST_NONE);
            4'd9:  c = mk(SRC_SY,  SRC_E1X, ACC_SUB,  1'b0, DST_QZ);
            4'd10: c = mk(SRC_E2X, SRC_QXL, ACC_LOAD, 1'b0, DST_NONE);
            4'd11: c = mk(SRC_E2X, SRC_QXH, ACC_ADD,  1'b1, DST_NONE);
            4'd12: c = mk(SRC_E2Y, SRC_QYL, ACC_ADD,  1'b0, DST_NONE);
            4'd13: c = mk(SRC_E2Y, SRC_QYH, ACC_ADD,  1'b1, DST_NONE);
            4'd14: c = mk(SRC_E2Z, SRC_QZL, ACC_ADD,  1'b0, DST_NONE);
            4'd15: c = mk(SRC_E2Z, SRC_QZH, ACC_ADD,  1'b1, DST_T);
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- src/point_in_mesh_ray_parity_unit.sv -----
`default_nettype none
// Triangles are taken one at a time, only in the idle state: each runs 16
// products on one shared signed multiplier, a product drain, a compare and a
// decision before the next is accepted; a last triangle waits in its decision
// state while the previous result is still held. A mesh result is registered
// and becomes valid when the decision of its last triangle is taken.
// Reset clears the query point, the crossing state and the result valid flag.
// ----------------------------------------------------------------------------
// point_in_mesh_ray_parity_unit: point-in-mesh test by ray crossing parity
// Counts crossings of the +x ray from the query point with streamed triangles
// and reports the parity and the count after the last triangle of a mesh.
// ----------------------------------------------------------------------------
module point_in_mesh_ray_parity_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pimr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pimr_pkg::CW-1:0]          i_cfg_data,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up.
    input  wire logic [pimr_pkg::IN_W-1:0]        i_s_axis_tdata,
    input  wire logic                             i_s_axis_tlast,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // inside_res, crossing_count, count_saturated from the lowest bit up.
    output logic [pimr_pkg::OUT_W-1:0]            o_m_axis_tdata
);

    pimr_pkg::t_dp_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    pimr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_last   (i_s_axis_tlast),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd)
    );

    pimr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tri       (i_s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_result    (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

// ----- src/pimr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pimr_ctrl: sequencer of the point-in-mesh ray parity unit
// Accepts a triangle, steps the datapath through the multiply-accumulate
// sequence, the compare and the decision, and owns the result valid flag.
// ----------------------------------------------------------------------------
module pimr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_last,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output pimr_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_EVAL,
        S_DECIDE
    } t_state;

    t_state                          r_state, n_state;
    logic [pimr_pkg::STEP_W-1:0]     r_step, n_step;
    logic                            r_last, n_last;
    logic                            r_out_valid, n_out_valid;
    pimr_pkg::t_dp_cmd               w_cmd;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_last  = r_last;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_last        = i_in_last;
                    n_step        = '0;
                    n_state       = S_RUN;
                end
            end
            S_RUN: begin
                if (r_step < pimr_pkg::STEP_W'(pimr_pkg::N_MAC)) begin
                    w_cmd.mac = pimr_pkg::step_cmd(r_step[pimr_pkg::MAC_IDX_W-1:0]);
                end
                if (r_step == pimr_pkg::STEP_W'(pimr_pkg::N_MAC)) begin
                    n_state = S_EVAL;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_EVAL: begin
                w_cmd.eval = 1'b1;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                if (!(r_last && r_out_valid && !i_out_ready)) begin
                    w_cmd.decide = 1'b1;
                    w_cmd.emit   = r_last;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = w_cmd.emit | (r_out_valid & ~i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule
`default_nettype wire

// ----- src/pimr_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pimr_dpath: datapath of the point-in-mesh ray parity unit
// Holds the query point, the edge vectors of the current triangle, one shared
// signed multiplier with a wide accumulator, the hit decision, the crossing
// counters and the result register.
// ----------------------------------------------------------------------------
module pimr_dpath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pimr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pimr_pkg::CW-1:0]          i_cfg_data,
    input  wire logic [pimr_pkg::IN_W-1:0]        i_tri,
    input  wire pimr_pkg::t_dp_cmd                i_cmd,
    output logic [pimr_pkg::OUT_W-1:0]            o_result
);

    localparam int CW  = pimr_pkg::CW;
    localparam int DW  = pimr_pkg::DW;
    localparam int PW  = pimr_pkg::PW;
    localparam int LW  = pimr_pkg::LW;
    localparam int HW  = pimr_pkg::HW;
    localparam int MW  = pimr_pkg::MW;
    localparam int PRW = pimr_pkg::PRW;
    localparam int TW  = pimr_pkg::TW;
    localparam int NB  = pimr_pkg::COUNT_BITS;

    function automatic logic signed [DW-1:0] diff(logic [CW-1:0] a, logic [CW-1:0] b);
        return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    logic [CW-1:0]               r_pt [0:2];
    logic signed [DW-1:0]        r_d [0:8];
    logic signed [PW-1:0]        r_q [0:2];
    logic signed [PW-1:0]        r_det, r_u;
    logic signed [TW-1:0]        r_t, r_acc, n_acc;
    logic signed [PRW-1:0]       r_prod;
    pimr_pkg::t_acc_op           r_op;
    logic                        r_hi;
    pimr_pkg::t_dst              r_dst;
    logic signed [PW:0]          r_du, r_uv;
    logic                        r_par, n_par;
    logic [NB-1:0]               r_tot, n_tot;
    logic                        r_cap, n_cap;
    logic [pimr_pkg::OUT_W-1:0]  r_res;

    logic [CW-1:0]               w_v [0:8];
    logic signed [MW-1:0]        w_opnd [0:15];
    logic signed [MW-1:0]        w_a, w_b;
    logic signed [TW-1:0]        w_ext, w_term;
    logic signed [PW+1:0]        w_w;
    logic                        w_dn, w_u_ok, w_v_ok, w_w_ok, w_t_ok, w_hit;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w_v[i] = i_tri[i*CW +: CW];
        end
    end

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w_opnd[i] = {{(MW-DW){r_d[i][DW-1]}}, r_d[i]};
        end
        for (int k = 0; k < 3; k++) begin
            w_opnd[9 + 2*k]  = $signed({{(MW-LW){1'b0}}, r_q[k][LW-1:0]});
            w_opnd[10 + 2*k] = {{(MW-HW){r_q[k][PW-1]}}, r_q[k][PW-1:LW]};
        end
        w_opnd[15] = '0;
    end

    assign w_a = w_opnd[i_cmd.mac.a_src];
    assign w_b = w_opnd[i_cmd.mac.b_src];

    assign w_ext  = {{(TW-PRW){r_prod[PRW-1]}}, r_prod};
    assign w_term = r_hi ? (w_ext <<< LW) : w_ext;

    always_comb begin
        case (r_op)
            pimr_pkg::ACC_LOAD: n_acc = w_term;
            pimr_pkg::ACC_ADD:  n_acc = r_acc + w_term;
            pimr_pkg::ACC_SUB:  n_acc = r_acc - w_term;
            default:            n_acc = r_acc;
        endcase
    end

    // With a negative determinant every bound flips direction instead of
    // negating the four values.
    assign w_w    = {{2{r_det[PW-1]}}, r_det} - {r_uv[PW], r_uv};
    assign w_dn   = r_det[PW-1];
    assign w_u_ok = w_dn ? ((r_u[PW-1] || r_u == '0) && (r_du[PW] || r_du == '0))
                         : (!r_u[PW-1] && !r_du[PW]);
    assign w_v_ok = w_dn ? (r_q[0][PW-1] || r_q[0] == '0) : !r_q[0][PW-1];
    assign w_w_ok = w_dn ? (w_w[PW+1] || w_w == '0) : !w_w[PW+1];
    assign w_t_ok = w_dn ? r_t[TW-1] : (!r_t[TW-1] && r_t != '0);
    assign w_hit  = (r_det != '0) && w_u_ok && w_v_ok && w_w_ok && w_t_ok;

    always_comb begin
        n_par = r_par ^ w_hit;
        n_tot = (w_hit && r_tot != '1) ? r_tot + 1'b1 : r_tot;
        n_cap = r_cap | (w_hit && n_tot == '1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt[0] <= '0;
            r_pt[1] <= '0;
            r_pt[2] <= '0;
            r_op    <= pimr_pkg::ACC_NONE;
            r_dst   <= pimr_pkg::DST_NONE;
            r_hi    <= 1'b0;
            r_par   <= 1'b0;
            r_tot   <= '0;
            r_cap   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pimr_pkg::REG_POINT_X: r_pt[0] <= i_cfg_data;
                    pimr_pkg::REG_POINT_Y: r_pt[1] <= i_cfg_data;
                    pimr_pkg::REG_POINT_Z: r_pt[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.mac.en) begin
                r_op  <= i_cmd.mac.op;
                r_dst <= i_cmd.mac.dst;
                r_hi  <= i_cmd.mac.hi;
            end else begin
                r_op  <= pimr_pkg::ACC_NONE;
                r_dst <= pimr_pkg::DST_NONE;
                r_hi  <= 1'b0;
            end
            if (i_cmd.decide) begin
                if (i_cmd.emit) begin
                    r_par <= 1'b0;
                    r_tot <= '0;
                    r_cap <= 1'b0;
                end else begin
                    r_par <= n_par;
                    r_tot <= n_tot;
                    r_cap <= n_cap;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k]     <= diff(w_v[3 + k], w_v[k]);
                r_d[3 + k] <= diff(w_v[6 + k], w_v[k]);
                r_d[6 + k] <= diff(r_pt[k], w_v[k]);
            end
        end
        r_prod <= w_a * w_b;
        r_acc  <= n_acc;
        case (r_dst)
            pimr_pkg::DST_DET: r_det  <= n_acc[PW-1:0];
            pimr_pkg::DST_U:   r_u    <= n_acc[PW-1:0];
            pimr_pkg::DST_QX:  r_q[0] <= n_acc[PW-1:0];
            pimr_pkg::DST_QY:  r_q[1] <= n_acc[PW-1:0];
            pimr_pkg::DST_QZ:  r_q[2] <= n_acc[PW-1:0];
            pimr_pkg::DST_T:   r_t    <= n_acc;
            default: ;
        endcase
        if (i_cmd.eval) begin
            r_du <= {r_det[PW-1], r_det} - {r_u[PW-1], r_u};
            r_uv <= {r_u[PW-1], r_u} + {r_q[0][PW-1], r_q[0]};
        end
        if (i_cmd.emit) begin
            r_res <= {{(pimr_pkg::OUT_W-NB-2){1'b0}}, n_cap, n_tot, n_par};
        end
    end

    assign o_result = r_res;

endmodule
`default_nettype wire

// ----- src/pimr_chk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pimr_chk: port checker of the point-in-mesh ray parity unit
// Watches the top-level ports for sequencing, result hold, reset and count ceiling.
// ----------------------------------------------------------------------------
module pimr_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_axis_tvalid,
    input wire logic                             o_s_axis_tready,
    input wire logic                             o_m_axis_tvalid,
    input wire logic                             i_m_axis_tready,
    input wire logic [pimr_pkg::OUT_W-1:0]       o_m_axis_tdata
);

    localparam int NB = pimr_pkg::COUNT_BITS;

    // A triangle keeps input ready low after its transfer.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready ##1 !o_s_axis_tready)
        else $error("input ready returned too early after a transfer");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("pending result changed or dropped");

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_saturated_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[NB+1] |-> o_m_axis_tdata[NB:1] == '1)
        else $error("saturated flag without a full count");

    // A new result can only appear while the unit is not taking a triangle.
    a_result_not_during_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared right after an input transfer");

endmodule

bind point_in_mesh_ray_parity_unit pimr_chk u_pimr_chk (.*);
`default_nettype wire
